[rtl/core/i2cm_pkg.sv]
// i2cm_pkg: shared types and constants for the i2c master bit sequencer
// no dependencies

package i2cm_pkg;

    localparam int unsigned HalfPeriodW   = 16;
    localparam int unsigned ByteW         = 8;
    localparam int unsigned BitIndexW     = 4;
    localparam logic [HalfPeriodW-1:0] HalfPeriodReset = 16'd5;
    localparam logic [BitIndexW-1:0]   BitsPerByte     = 4'd8;
    localparam logic [2:0]             OpUnused        = 3'd7;

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_WRITE     = 3'd2,
        OP_READ      = 3'd3,
        OP_READ_ACK  = 3'd4,
        OP_SEND_ACK  = 3'd5,
        OP_SEND_NACK = 3'd6
    } t_op;

    typedef struct packed {
        logic             cmd_valid;
        logic [2:0]       op;
        logic [ByteW-1:0] tx_byte;
        logic             sda_in;
    } t_in_item;

    typedef struct packed {
        logic             scl_level;
        logic             sda_level;
        logic             busy_res;
        logic             done_res;
        logic [ByteW-1:0] rx_byte;
        logic             ack_bit;
    } t_out_item;

    // classified tick as it sits in the queue
    typedef struct packed {
        logic             go;
        t_op              op;
        logic [ByteW-1:0] tx_byte;
        logic             sda_in;
    } t_tick;

endpackage

[rtl/core/i2cm_front.sv]
// i2cm_front: accepts tick transactions, decodes the command and queues them
// depends on i2cm_pkg

module i2cm_front
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in_item,
    input  logic     i_pop,
    output logic     o_tick_valid,
    output t_tick    o_tick
);

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LastAddr = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

    t_tick          r_mem [QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    t_tick          w_tick;
    logic           w_push;
    logic           w_pop;

    // classify: unused op is no command
    always_comb begin
        w_tick.go      = i_in_item.cmd_valid && (i_in_item.op != OpUnused);
        w_tick.op      = w_tick.go ? t_op'(i_in_item.op) : OP_START;
        w_tick.tx_byte = i_in_item.tx_byte;
        w_tick.sda_in  = i_in_item.sda_in;
    end

    assign o_in_ready   = (r_count != FullCount);
    assign o_tick_valid = (r_count != '0);
    assign o_tick       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = i_pop && o_tick_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LastAddr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LastAddr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_tick;
        end
    end

endmodule

[rtl/core/i2cm_back.sv]
// i2cm_back: scl/sda line sequencer, runs one queued tick per cycle into the output register
// while not stalled by i_out_ready; depends on i2cm_pkg

module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [HalfPeriodW-1:0] i_cfg_wdata,
    input  logic                   i_tick_valid,
    input  t_tick                  i_tick,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START_A,
        PH_START_B,
        PH_STOP_A,
        PH_STOP_B,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } t_phase;

    logic [HalfPeriodW-1:0] r_half_period;
    t_phase                 r_phase, n_phase;
    logic [BitIndexW-1:0]   r_bit_index, n_bit_index;
    logic [ByteW-1:0]       r_shift, n_shift;
    t_op                    r_active_op, n_active_op;
    logic [HalfPeriodW-1:0] r_delay, n_delay;
    logic                   r_scl, n_scl;
    logic                   r_sda, n_sda;
    logic                   r_ack, n_ack;
    logic [ByteW-1:0]       r_rx, n_rx;
    logic                   r_out_valid;
    t_out_item              r_out, n_out;

    logic [HalfPeriodW-1:0] w_load;
    logic [ByteW-1:0]       w_sh;
    logic [BitIndexW-1:0]   w_bi;
    logic [BitIndexW-1:0]   w_bi_m1;
    logic                   w_reads;
    logic                   w_done;

    assign o_pop       = i_tick_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_load      = (r_half_period == '0) ? HalfPeriodW'(1) : r_half_period;
    assign w_reads     = (r_active_op == OP_READ) || (r_active_op == OP_READ_ACK);

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_active_op = r_active_op;
        n_delay     = r_delay;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_ack       = r_ack;
        n_rx        = r_rx;
        w_done      = 1'b0;
        w_sh        = r_shift;
        w_bi        = r_bit_index;
        w_bi_m1     = r_bit_index;
        if (r_phase == PH_IDLE) begin
            if (i_tick.go) begin
                n_active_op = i_tick.op;
                n_delay     = w_load;
                unique case (i_tick.op)
                    OP_START: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_phase = PH_START_A;
                    end
                    OP_STOP: begin
                        n_scl   = 1'b0;
                        n_sda   = 1'b0;
                        n_phase = PH_STOP_A;
                    end
                    OP_WRITE: begin
                        n_shift     = i_tick.tx_byte;
                        n_bit_index = BitsPerByte;
                        n_sda       = i_tick.tx_byte[ByteW-1];
                        n_phase     = PH_BIT_LOW;
                    end
                    OP_READ: begin
                        n_shift     = '0;
                        n_bit_index = BitsPerByte;
                        n_sda       = 1'b1;
                        n_phase     = PH_BIT_LOW;
                    end
                    OP_READ_ACK: begin
                        n_bit_index = BitIndexW'(1);
                        n_sda       = 1'b1;
                        n_phase     = PH_BIT_LOW;
                    end
                    OP_SEND_ACK, OP_SEND_NACK: begin
                        n_shift     = {{(ByteW-1){1'b0}}, (i_tick.op == OP_SEND_NACK)};
                        n_bit_index = BitIndexW'(1);
                        n_sda       = (i_tick.op == OP_SEND_NACK);
                        n_phase     = PH_BIT_LOW;
                    end
                endcase
            end
        end else if (r_delay > HalfPeriodW'(1)) begin
            n_delay = r_delay - 1'b1;
        end else begin
            unique case (r_phase)
                PH_START_A: begin
                    n_sda   = 1'b0;
                    n_phase = PH_START_B;
                    n_delay = w_load;
                end
                PH_START_B: begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
                PH_STOP_A: begin
                    n_scl   = 1'b1;
                    n_phase = PH_STOP_B;
                    n_delay = w_load;
                end
                PH_STOP_B: begin
                    n_sda   = 1'b1;
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end
                PH_BIT_LOW: begin
                    n_scl   = 1'b1;
                    n_phase = PH_BIT_HIGH;
                    n_delay = w_load;
                end
                PH_BIT_HIGH, PH_IDLE: begin
                    if (r_active_op == OP_READ) begin
                        w_sh = {r_shift[ByteW-2:0], i_tick.sda_in};
                    end else if (r_active_op == OP_READ_ACK) begin
                        n_ack = i_tick.sda_in;
                    end
                    n_scl       = 1'b0;
                    w_bi        = r_bit_index - 1'b1;
                    w_bi_m1     = w_bi - 1'b1;
                    n_bit_index = w_bi;
                    n_shift     = w_sh;
                    if (w_bi == '0) begin
                        if (r_active_op == OP_READ) begin
                            n_rx = w_sh;
                        end
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end else begin
                        n_sda   = w_reads ? 1'b1 : w_sh[w_bi_m1[2:0]];
                        n_phase = PH_BIT_LOW;
                        n_delay = w_load;
                    end
                end
            endcase
        end
        n_out.scl_level = n_scl;
        n_out.sda_level = n_sda;
        n_out.busy_res  = (n_phase != PH_IDLE);
        n_out.done_res  = w_done;
        n_out.rx_byte   = n_rx;
        n_out.ack_bit   = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HalfPeriodReset;
            r_phase       <= PH_IDLE;
            r_bit_index   <= '0;
            r_shift       <= '0;
            r_active_op   <= OP_START;
            r_delay       <= '0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_ack         <= 1'b0;
            r_rx          <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half_period <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_bit_index <= n_bit_index;
                r_shift     <= n_shift;
                r_active_op <= n_active_op;
                r_delay     <= n_delay;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_ack       <= n_ack;
                r_rx        <= n_rx;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/core/i2c_master_bit_sequencer.sv]
// i2c_master_bit_sequencer: top level, tick queue in front of the scl/sda sequencer
// depends on i2cm_pkg, i2cm_front, i2cm_back
//
// usage
//   input channel: one transaction per timing tick, carrying an optional command
//   (start, stop, write byte, read byte, read ack, send ack, send nack) and the
//   sampled sda level. output channel: one transaction per input tick with the
//   scl/sda line levels, busy, a done pulse, the last read byte and ack bit.
//   i_cfg_we writes half_period, the ticks per scl phase; write it only while idle.
// datapath and throughput
//   a tick is written into the queue, then popped into the output register.
//   one tick per cycle sustained while i_out_ready stays high.
// reset
//   lines released high, sequencer idle, half_period 5, queue and output empty.
// stalls
//   when i_out_ready is low the result is held in the output register and up to
//   QUEUE_DEPTH further ticks are taken into the queue before o_in_ready drops.

module i2c_master_bit_sequencer
    import i2cm_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [HalfPeriodW-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_in_item               i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_item
);

    logic  w_tick_valid;
    t_tick w_tick;
    logic  w_pop;

    i2cm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_pop        (w_pop),
        .o_tick_valid (w_tick_valid),
        .o_tick       (w_tick)
    );

    i2cm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_tick_valid (w_tick_valid),
        .i_tick       (w_tick),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_item   (o_out_item)
    );

endmodule

[verif/tb_i2c_master_bit_sequencer.sv]
// tb_i2c_master_bit_sequencer: self-checking testbench for the i2c master bit sequencer
// depends on i2cm_pkg and i2c_master_bit_sequencer; drives ticks, predicts every output field per tick
// directed command table first, then random command streams over several half periods

module tb_i2c_master_bit_sequencer;
    import i2cm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 1000;
    localparam int DIR_N = 16;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START_A,
        SEQ_START_B,
        SEQ_STOP_A,
        SEQ_STOP_B,
        SEQ_BIT_LOW,
        SEQ_BIT_HIGH
    } t_seq_phase;

    typedef struct packed {
        logic      check;
        logic      drain;
        t_in_item  tick;
        t_out_item want;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{1'b1, 1'b0, '{1'b0, OpUnused, 8'hFF, 1'b1}, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, 1'b0, '{1'b1, OpUnused, 8'h5A, 1'b0}, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
        '{1'b1, 1'b1, '{1'b1, OP_START, 8'h00, 1'b0}, '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1'b1, 1'b1, '{1'b1, OP_WRITE, 8'hFF, 1'b0}, '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1'b1, 1'b1, '{1'b1, OP_WRITE, 8'h00, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}},
        '{1'b0, 1'b1, '{1'b1, OP_READ_ACK, 8'h00, 1'b1}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_READ, 8'hFF, 1'b0}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_SEND_ACK, 8'hFF, 1'b1}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_SEND_NACK, 8'h00, 1'b0}, '0},
        '{1'b0, 1'b0, '{1'b1, OP_START, 8'h00, 1'b1}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_WRITE, 8'hA5, 1'b0}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_STOP, 8'h00, 1'b0}, '0},
        '{1'b0, 1'b0, '{1'b0, OP_WRITE, 8'hFF, 1'b1}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_READ, 8'h00, 1'b1}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_READ_ACK, 8'hFF, 1'b0}, '0},
        '{1'b0, 1'b1, '{1'b1, OP_STOP, 8'hFF, 1'b1}, '0}
    };

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [HalfPeriodW-1:0] cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               in_item = '0;
    logic                   o_out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              o_out_item;

    i2c_master_bit_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    // sequencer shadow state
    logic [HalfPeriodW-1:0] hp_cfg = HalfPeriodReset;
    t_seq_phase             ph = SEQ_IDLE;
    logic [BitIndexW-1:0]   bits_left = '0;
    logic [ByteW-1:0]       shifter = '0;
    t_op                    cur_op = OP_START;
    logic [HalfPeriodW-1:0] delay_left = '0;
    logic                   scl_q = 1'b1;
    logic                   sda_q = 1'b1;
    logic                   ack_q = 1'b0;
    logic [ByteW-1:0]       rx_q = '0;

    t_out_item pending_lines [$];
    int        mismatches = 0;
    int        idle_pct = 0;
    int        quiet_cycles = 0;
    t_out_item want;

    function automatic void reload_delay();
        delay_left = (hp_cfg == '0) ? HalfPeriodW'(1) : hp_cfg;
    endfunction

    function automatic void drive_next_bit();
        if (cur_op == OP_READ || cur_op == OP_READ_ACK) begin
            sda_q = 1'b1;
        end else begin
            sda_q = shifter[3'(bits_left - 4'd1)];
        end
        ph = SEQ_BIT_LOW;
        reload_delay();
    endfunction

    function automatic t_out_item step_sequencer(input t_in_item tk);
        t_out_item r;
        logic      fin;
        fin = 1'b0;
        if (ph == SEQ_IDLE) begin
            if (tk.cmd_valid && tk.op != OpUnused) begin
                cur_op = t_op'(tk.op);
                case (cur_op)
                    OP_START: begin
                        scl_q = 1'b1;
                        sda_q = 1'b1;
                        ph = SEQ_START_A;
                        reload_delay();
                    end
                    OP_STOP: begin
                        scl_q = 1'b0;
                        sda_q = 1'b0;
                        ph = SEQ_STOP_A;
                        reload_delay();
                    end
                    OP_WRITE: begin
                        shifter = tk.tx_byte;
                        bits_left = BitsPerByte;
                        drive_next_bit();
                    end
                    OP_READ: begin
                        shifter = '0;
                        bits_left = BitsPerByte;
                        drive_next_bit();
                    end
                    OP_READ_ACK: begin
                        bits_left = 4'd1;
                        drive_next_bit();
                    end
                    default: begin
                        shifter = (cur_op == OP_SEND_NACK) ? 8'd1 : 8'd0;
                        bits_left = 4'd1;
                        drive_next_bit();
                    end
                endcase
            end
        end else if (delay_left > 1) begin
            delay_left = delay_left - 1'b1;
        end else begin
            case (ph)
                SEQ_START_A: begin
                    sda_q = 1'b0;
                    ph = SEQ_START_B;
                    reload_delay();
                end
                SEQ_START_B: begin
                    scl_q = 1'b0;
                    ph = SEQ_IDLE;
                    fin = 1'b1;
                end
                SEQ_STOP_A: begin
                    scl_q = 1'b1;
                    ph = SEQ_STOP_B;
                    reload_delay();
                end
                SEQ_STOP_B: begin
                    sda_q = 1'b1;
                    ph = SEQ_IDLE;
                    fin = 1'b1;
                end
                SEQ_BIT_LOW: begin
                    scl_q = 1'b1;
                    ph = SEQ_BIT_HIGH;
                    reload_delay();
                end
                default: begin
                    if (cur_op == OP_READ) begin
                        shifter = {shifter[ByteW-2:0], tk.sda_in};
                    end else if (cur_op == OP_READ_ACK) begin
                        ack_q = tk.sda_in;
                    end
                    scl_q = 1'b0;
                    bits_left = bits_left - 4'd1;
                    if (bits_left == '0) begin
                        if (cur_op == OP_READ) begin
                            rx_q = shifter;
                        end
                        ph = SEQ_IDLE;
                        fin = 1'b1;
                    end else begin
                        drive_next_bit();
                    end
                end
            endcase
        end
        r.scl_level = scl_q;
        r.sda_level = sda_q;
        r.busy_res  = (ph != SEQ_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_q;
        r.ack_bit   = ack_q;
        return r;
    endfunction

    function automatic t_in_item quiet_tick();
        t_in_item tk;
        tk.cmd_valid = 1'b0;
        tk.op        = 3'($urandom_range(7));
        tk.tx_byte   = 8'($urandom_range(255));
        tk.sda_in    = 1'($urandom_range(1));
        return tk;
    endfunction

    function automatic t_in_item random_tick();
        t_in_item tk;
        int       r;
        tk = quiet_tick();
        r = $urandom_range(99);
        if (ph == SEQ_IDLE) begin
            if (r < 80) begin
                tk.cmd_valid = 1'b1;
                tk.op = 3'($urandom_range(6));
            end else if (r < 88) begin
                tk.cmd_valid = 1'b1;
                tk.op = OpUnused;
            end
        end else if (r < 8 || (delay_left <= 1 && r < 50)) begin
            // lands a command on busy ticks, often on the finishing one
            tk.cmd_valid = 1'b1;
        end
        return tk;
    endfunction

    task automatic push_tick(input t_in_item tk, input logic typed, input t_out_item typed_out);
        t_out_item guess;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= tk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        guess = step_sequencer(tk);
        pending_lines.push_back(typed ? typed_out : guess);
    endtask

    task automatic finish_command();
        while (ph != SEQ_IDLE) push_tick(quiet_tick(), 1'b0, '0);
    endtask

    task automatic run_phase(input logic [HalfPeriodW-1:0] hp, input int n, input int pct);
        in_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= hp;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        hp_cfg = hp;
        idle_pct = pct;
        repeat (n) push_tick(random_tick(), 1'b0, '0);
        finish_command();
    endtask

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        @(posedge i_clk);
        forever begin
            if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_lines.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                if (o_out_item.scl_level !== want.scl_level) begin
                    $error("scl_level expected %0d actual %0d", want.scl_level,
                           o_out_item.scl_level);
                    mismatches++;
                end
                if (o_out_item.sda_level !== want.sda_level) begin
                    $error("sda_level expected %0d actual %0d", want.sda_level,
                           o_out_item.sda_level);
                    mismatches++;
                end
                if (o_out_item.busy_res !== want.busy_res) begin
                    $error("busy_res expected %0d actual %0d", want.busy_res,
                           o_out_item.busy_res);
                    mismatches++;
                end
                if (o_out_item.done_res !== want.done_res) begin
                    $error("done_res expected %0d actual %0d", want.done_res,
                           o_out_item.done_res);
                    mismatches++;
                end
                if (o_out_item.rx_byte !== want.rx_byte) begin
                    $error("rx_byte expected %0h actual %0h", want.rx_byte,
                           o_out_item.rx_byte);
                    mismatches++;
                end
                if (o_out_item.ack_bit !== want.ack_bit) begin
                    $error("ack_bit expected %0d actual %0d", want.ack_bit,
                           o_out_item.ack_bit);
                    mismatches++;
                end
            end
        end
    end

    // no transaction on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("i2c_master_bit_sequencer verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 15;
        for (int i = 0; i < DIR_N; i++) begin
            push_tick(DIR_ROWS[i].tick, DIR_ROWS[i].check, DIR_ROWS[i].want);
            if (DIR_ROWS[i].drain) begin
                finish_command();
            end
        end
        finish_command();

        run_phase(16'd1, 100, 25);
        run_phase(16'd0, 50, 10);
        run_phase(16'd3, 50, 40);
        // long half period, one start only
        run_phase(16'd20, 0, 0);
        push_tick('{1'b1, OP_START, 8'h00, 1'b0}, 1'b0, '0);
        finish_command();
        run_phase(16'd2, 40, 20);
        run_phase(16'd1, 60, 0);

        in_valid <= 1'b0;
        while (pending_lines.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("i2c_master_bit_sequencer verification clean");
        end else begin
            $display("i2c_master_bit_sequencer verification failed");
        end
        $finish;
    end

endmodule
